/* hdl/triangle_near_clip_viewport_core_assert.svh */
// Assertion macros for the triangle near-clip viewport core.
`ifndef TRIANGLE_NEAR_CLIP_VIEWPORT_CORE_ASSERT_SVH
`define TRIANGLE_NEAR_CLIP_VIEWPORT_CORE_ASSERT_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define TNCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never hold.
`define TNCV_NEVER(lbl, expr, msg) \
  `TNCV_ASSERT(lbl, !(expr), msg)

`endif

/* hdl/tncv_pkg.sv */
// Shared types, constants and helpers of the triangle near-clip viewport core.
package tncv_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int OPW     = COORD_W + 2;
  localparam int PROD_W  = 2 * OPW;
  localparam int CNT_W   = $clog2(PROD_W);
  localparam int FB_W    = 13;
  localparam int SCR_W   = OPW + FB_W + 1;
  localparam int NEAR_W  = FRAC_W + 1;
  localparam int CFG_W   = NEAR_W;
  localparam int NSLOT   = 5;
  localparam int SLOT_W  = 3;
  localparam int RGB_W   = 24;

  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [OPW-1:0] FIX_ONE = {{(OPW-FRAC_W-1){1'b0}}, 1'b1,
                                               {FRAC_W{1'b0}}};

  localparam logic [FB_W-1:0]   FBW_RST  = FB_W'(640);
  localparam logic [FB_W-1:0]   FBH_RST  = FB_W'(480);
  localparam logic [NEAR_W-1:0] NEAR_RST = NEAR_W'(66);

  localparam logic [SLOT_W-1:0] SLOT_V0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_V1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_V2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_E0 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_E1 = 3'd4;

  typedef enum logic [1:0] {
    CFG_FB_WIDTH  = 2'd0,
    CFG_FB_HEIGHT = 2'd1,
    CFG_NEAR      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_EDGE,
    OP_NDC,
    OP_SCR
  } op_sel_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_E_RDIN,
    ST_E_RDOUT,
    ST_E_GO,
    ST_E_WAIT,
    ST_N_RD,
    ST_N_GO,
    ST_N_WAIT,
    ST_CULL,
    ST_S_GO,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic              load_vtx;
    logic              ld_color;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic              lat_in;
    logic              md_start;
    op_sel_e           op;
    logic [1:0]        comp;
    logic [1:0]        vi;
    logic              edge_wr;
    logic              ndc_wr;
    logic              scr_wr;
    logic              out_load;
    logic              out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] front;
    logic       md_done;
    logic       md_busy;
    logic       cull;
    logic       out_free;
  } dp_sts_t;

  function automatic logic signed [OPW-1:0] sext_op(input logic signed [COORD_W-1:0] v);
    return {{(OPW-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
    if (v[COORD_W] != v[COORD_W-1]) begin
      return v[COORD_W] ? CMIN : CMAX;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

/* hdl/tncv_muldiv.sv */
// Sequential trunc(a*b/c) unit: shift-add multiply, restoring divide, saturation.
module tncv_muldiv import tncv_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [OPW-1:0]     a_i,
  input  logic signed [OPW-1:0]     b_i,
  input  logic signed [OPW-1:0]     c_i,
  output logic                      done_o,
  output logic                      busy_o,
  output logic signed [COORD_W-1:0] res_o
);

  md_state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [OPW-1:0]    ma_q, ma_d, mc_q, mc_d, r_q, r_d;
  logic [PROD_W-1:0] p_q, p_d;
  logic              neg_q, neg_d, zero_q, zero_d, cz_q, cz_d;

  logic [OPW-1:0] ma, mb, mc;
  logic [OPW:0]   sum, rs;
  logic           ge, big;
  logic [COORD_W-1:0] qlo;

  assign ma = a_i[OPW-1] ? OPW'(-a_i) : a_i;
  assign mb = b_i[OPW-1] ? OPW'(-b_i) : b_i;
  assign mc = c_i[OPW-1] ? OPW'(-c_i) : c_i;

  assign sum = {1'b0, p_q[PROD_W-1:OPW]} + (p_q[0] ? {1'b0, ma_q} : '0);
  assign rs  = {r_q, p_q[PROD_W-1]};
  assign ge  = rs >= {1'b0, mc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    ma_q   <= ma_d;
    mc_q   <= mc_d;
    r_q    <= r_d;
    p_q    <= p_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    cz_q   <= cz_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ma_d    = ma_q;
    mc_d    = mc_q;
    r_d     = r_q;
    p_d     = p_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    cz_d    = cz_q;
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          ma_d   = ma;
          mc_d   = mc;
          p_d    = {{OPW{1'b0}}, mb};
          r_d    = '0;
          cnt_d  = '0;
          zero_d = (ma == '0) || (mb == '0);
          cz_d   = (mc == '0);
          // divisor sign only counts when the divisor is nonzero
          neg_d  = a_i[OPW-1] ^ b_i[OPW-1] ^ (c_i[OPW-1] && (mc != '0));
          state_d = ((ma == '0) || (mb == '0) || (mc == '0)) ? MD_DONE : MD_MUL;
        end
      end
      MD_MUL: begin
        p_d   = {sum, p_q[OPW-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(OPW-1)) begin
          cnt_d   = '0;
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        r_d   = ge ? OPW'(rs - {1'b0, mc_q}) : rs[OPW-1:0];
        p_d   = {p_q[PROD_W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PROD_W-1)) begin
          state_d = MD_DONE;
        end
      end
      MD_DONE: state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  assign big = |p_q[PROD_W-1:COORD_W-1];
  assign qlo = p_q[COORD_W-1:0];

  always_comb begin
    if (zero_q) begin
      res_o = '0;
    end else if (cz_q || big) begin
      res_o = neg_q ? CMIN : CMAX;
    end else begin
      res_o = neg_q ? COORD_W'(-qlo) : qlo;
    end
  end

  assign done_o = (state_q == MD_DONE);
  assign busy_o = (state_q != MD_IDLE);

endmodule

/* hdl/tncv_dp.sv */
// Datapath: config registers, vertex slots, NDC/screen results, output beat register.
module tncv_dp import tncv_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  input  logic signed [COORD_W-1:0] clip_x_i,
  input  logic signed [COORD_W-1:0] clip_y_i,
  input  logic signed [COORD_W-1:0] clip_z_i,
  input  logic signed [COORD_W-1:0] clip_w_i,
  input  logic [RGB_W-1:0]          color_rgb_i,
  input  logic                      color_present_i,
  input  dp_cmd_t                   cmd_i,
  output dp_sts_t                   sts_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic signed [COORD_W-1:0] sx0_o,
  output logic signed [COORD_W-1:0] sy0_o,
  output logic signed [COORD_W-1:0] sz0_o,
  output logic signed [COORD_W-1:0] sx1_o,
  output logic signed [COORD_W-1:0] sy1_o,
  output logic signed [COORD_W-1:0] sz1_o,
  output logic signed [COORD_W-1:0] sx2_o,
  output logic signed [COORD_W-1:0] sy2_o,
  output logic signed [COORD_W-1:0] sz2_o,
  output logic [31:0]               rgba_o,
  output logic                      last_of_run_o
);

  logic [FB_W-1:0]   fbw_q, fbh_q;
  logic [NEAR_W-1:0] near_q;

  logic signed [COORD_W-1:0] vert_q [NSLOT][4];
  logic signed [COORD_W-1:0] rd_q [4];
  logic signed [COORD_W-1:0] in_q [4];
  logic signed [COORD_W-1:0] ndc_q [3][3];
  logic signed [COORD_W-1:0] scr_q [3][2];
  logic [31:0]               rgba_q;

  logic                      out_valid_q;
  logic signed [COORD_W-1:0] sx_q [3];
  logic signed [COORD_W-1:0] sy_q [3];
  logic signed [COORD_W-1:0] sz_q [3];
  logic [31:0]               orgba_q;
  logic                      olast_q;

  logic signed [OPW-1:0]     op_a, op_b, op_c, near_op;
  logic signed [COORD_W-1:0] md_res;
  logic                      md_done, md_busy, out_free;
  logic signed [COORD_W:0]   near_s, edge_sum;
  logic [2:0]                front;
  logic                      cull;

  logic signed [OPW-1:0]     scr_a;
  logic [FB_W-1:0]           scr_size;
  logic signed [SCR_W-1:0]   scr_p, scr_h;
  logic                      scr_fit;
  logic signed [COORD_W-1:0] scr_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbw_q       <= FBW_RST;
      fbh_q       <= FBH_RST;
      near_q      <= NEAR_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FB_WIDTH:  fbw_q  <= cfg_wdata_i[FB_W-1:0];
          CFG_FB_HEIGHT: fbh_q  <= cfg_wdata_i[FB_W-1:0];
          CFG_NEAR:      near_q <= cfg_wdata_i[NEAR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign near_op  = $signed({{(OPW-NEAR_W){1'b0}}, near_q});
  assign near_s   = $signed({{(COORD_W+1-NEAR_W){1'b0}}, near_q});
  assign edge_sum = {in_q[cmd_i.comp][COORD_W-1], in_q[cmd_i.comp]}
                  + {md_res[COORD_W-1], md_res};

  // screen = trunc((ndc + 1) * size / 2)
  assign scr_a    = sext_op(ndc_q[cmd_i.vi][{1'b0, cmd_i.comp[0]}]) + FIX_ONE;
  assign scr_size = cmd_i.comp[0] ? fbh_q : fbw_q;
  assign scr_p    = scr_a * $signed({1'b0, scr_size});
  // bias negative products so the halving truncates toward zero
  assign scr_h    = $signed(scr_p + SCR_W'(scr_p[SCR_W-1])) >>> 1;
  assign scr_fit  = (scr_h[SCR_W-1:COORD_W-1] == '0) || (scr_h[SCR_W-1:COORD_W-1] == '1);
  assign scr_val  = scr_fit ? scr_h[COORD_W-1:0] : (scr_h[SCR_W-1] ? CMIN : CMAX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vtx) begin
      vert_q[cmd_i.wr_slot][0] <= clip_x_i;
      vert_q[cmd_i.wr_slot][1] <= clip_y_i;
      vert_q[cmd_i.wr_slot][2] <= clip_z_i;
      vert_q[cmd_i.wr_slot][3] <= clip_w_i;
    end else if (cmd_i.edge_wr && md_done) begin
      vert_q[cmd_i.wr_slot][cmd_i.comp] <= sat_coord(edge_sum);
    end
    if (cmd_i.ld_color) begin
      rgba_q <= {(color_present_i ? color_rgb_i : {RGB_W{1'b1}}), 8'hFF};
    end
    rd_q <= vert_q[cmd_i.rd_slot];
    if (cmd_i.lat_in) begin
      in_q <= rd_q;
    end
    if (cmd_i.ndc_wr && md_done) begin
      ndc_q[cmd_i.vi][cmd_i.comp] <= md_res;
    end
    if (cmd_i.scr_wr) begin
      scr_q[cmd_i.vi][cmd_i.comp[0]] <= scr_val;
    end
    if (cmd_i.out_load) begin
      for (int i = 0; i < 3; i++) begin
        sx_q[i] <= scr_q[i][0];
        sy_q[i] <= scr_q[i][1];
        sz_q[i] <= ndc_q[i][2];
      end
      orgba_q <= rgba_q;
      olast_q <= cmd_i.out_last;
    end
  end

  always_comb begin
    case (cmd_i.op)
      OP_EDGE: begin
        op_a = sext_op(rd_q[cmd_i.comp]) - sext_op(in_q[cmd_i.comp]);
        op_b = near_op - sext_op(in_q[3]);
        op_c = sext_op(rd_q[3]) - sext_op(in_q[3]);
      end
      OP_NDC: begin
        op_a = sext_op(rd_q[cmd_i.comp]);
        op_b = FIX_ONE;
        op_c = sext_op(rd_q[3]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
        op_c = '0;
      end
    endcase
  end

  tncv_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.md_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .c_i     (op_c),
    .done_o  (md_done),
    .busy_o  (md_busy),
    .res_o   (md_res)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      front[i] = $signed({vert_q[i][3][COORD_W-1], vert_q[i][3]}) >= near_s;
    end
    cull = 1'b0;
    for (int k = 0; k < 2; k++) begin
      if (sext_op(ndc_q[0][k]) < -FIX_ONE && sext_op(ndc_q[1][k]) < -FIX_ONE &&
          sext_op(ndc_q[2][k]) < -FIX_ONE) begin
        cull = 1'b1;
      end
      if (sext_op(ndc_q[0][k]) > FIX_ONE && sext_op(ndc_q[1][k]) > FIX_ONE &&
          sext_op(ndc_q[2][k]) > FIX_ONE) begin
        cull = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.front    = front;
  assign sts_o.md_done  = md_done;
  assign sts_o.md_busy  = md_busy;
  assign sts_o.cull     = cull;
  assign sts_o.out_free = out_free;

  assign out_valid_o   = out_valid_q;
  assign sx0_o         = sx_q[0];
  assign sy0_o         = sy_q[0];
  assign sz0_o         = sz_q[0];
  assign sx1_o         = sx_q[1];
  assign sy1_o         = sy_q[1];
  assign sz1_o         = sz_q[1];
  assign sx2_o         = sx_q[2];
  assign sy2_o         = sy_q[2];
  assign sz2_o         = sz_q[2];
  assign rgba_o        = orgba_q;
  assign last_of_run_o = olast_q;

endmodule

/* hdl/tncv_ctrl.sv */
// Controller: vertex gathering, clip classification and operation sequencing.
module tncv_ctrl import tncv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [1:0]  vcnt_q, vcnt_d;
  logic        e_idx_q, e_idx_d;
  logic [1:0]  k_q, k_d;
  logic [1:0]  vi_q, vi_d;
  logic        t_q, t_d;
  logic        tlast_q, tlast_d;
  logic        full_q, full_d;
  logic [SLOT_W-1:0] tri_q [2][3];
  logic [SLOT_W-1:0] tri_d [2][3];
  logic [SLOT_W-1:0] ein_q [2];
  logic [SLOT_W-1:0] ein_d [2];
  logic [SLOT_W-1:0] eout_q [2];
  logic [SLOT_W-1:0] eout_d [2];

  logic [SLOT_W-1:0] f_s, j_s, m_s, a_s, b_s, c_s;

  // single in-front vertex f with neighbors j, m; single behind vertex b
  always_comb begin
    case (sts_i.front)
      3'b001, 3'b110: begin
        f_s = SLOT_V0; j_s = SLOT_V1; m_s = SLOT_V2;
        a_s = SLOT_V1; b_s = SLOT_V0; c_s = SLOT_V2;
      end
      3'b010, 3'b101: begin
        f_s = SLOT_V1; j_s = SLOT_V0; m_s = SLOT_V2;
        a_s = SLOT_V2; b_s = SLOT_V1; c_s = SLOT_V0;
      end
      default: begin
        f_s = SLOT_V2; j_s = SLOT_V0; m_s = SLOT_V1;
        a_s = SLOT_V0; b_s = SLOT_V2; c_s = SLOT_V1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      vcnt_q  <= vcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_idx_q <= e_idx_d;
    k_q     <= k_d;
    vi_q    <= vi_d;
    t_q     <= t_d;
    tlast_q <= tlast_d;
    full_q  <= full_d;
    tri_q   <= tri_d;
    ein_q   <= ein_d;
    eout_q  <= eout_d;
  end

  always_comb begin
    state_d = state_q;
    vcnt_d  = vcnt_q;
    e_idx_d = e_idx_q;
    k_d     = k_q;
    vi_d    = vi_q;
    t_d     = t_q;
    tlast_d = tlast_q;
    full_d  = full_q;
    tri_d   = tri_q;
    ein_d   = ein_q;
    eout_d  = eout_q;
    in_ready_o = 1'b0;
    cmd_o   = '0;
    cmd_o.op   = OP_EDGE;
    cmd_o.comp = k_q;
    cmd_o.vi   = vi_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.wr_slot = {1'b0, vcnt_q};
        if (in_valid_i) begin
          cmd_o.load_vtx = 1'b1;
          if (vcnt_q == 2'd2) begin
            cmd_o.ld_color = 1'b1;
            vcnt_d  = '0;
            state_d = ST_CLASS;
          end else begin
            vcnt_d = vcnt_q + 1'b1;
          end
        end
      end
      ST_CLASS: begin
        e_idx_d = 1'b0;
        k_d     = '0;
        vi_d    = '0;
        t_d     = 1'b0;
        case ($countones(sts_i.front))
          1: begin
            ein_d[0] = f_s; eout_d[0] = j_s;
            ein_d[1] = f_s; eout_d[1] = m_s;
            tri_d[0][0] = f_s; tri_d[0][1] = SLOT_E0; tri_d[0][2] = SLOT_E1;
            tlast_d = 1'b0;
            full_d  = 1'b0;
            state_d = ST_E_RDIN;
          end
          2: begin
            ein_d[0] = c_s; eout_d[0] = b_s;
            ein_d[1] = a_s; eout_d[1] = b_s;
            tri_d[0][0] = a_s; tri_d[0][1] = c_s;     tri_d[0][2] = SLOT_E0;
            tri_d[1][0] = a_s; tri_d[1][1] = SLOT_E0; tri_d[1][2] = SLOT_E1;
            tlast_d = 1'b1;
            full_d  = 1'b0;
            state_d = ST_E_RDIN;
          end
          3: begin
            tri_d[0][0] = SLOT_V0; tri_d[0][1] = SLOT_V1; tri_d[0][2] = SLOT_V2;
            tlast_d = 1'b0;
            full_d  = 1'b1;
            state_d = ST_N_RD;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_E_RDIN: begin
        cmd_o.rd_slot = ein_q[e_idx_q];
        state_d = ST_E_RDOUT;
      end
      ST_E_RDOUT: begin
        cmd_o.rd_slot = eout_q[e_idx_q];
        cmd_o.lat_in  = 1'b1;
        state_d = ST_E_GO;
      end
      ST_E_GO: begin
        cmd_o.md_start = 1'b1;
        state_d = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        cmd_o.edge_wr = 1'b1;
        cmd_o.wr_slot = e_idx_q ? SLOT_E1 : SLOT_E0;
        if (sts_i.md_done) begin
          if (k_q == 2'd3) begin
            k_d = '0;
            if (e_idx_q) begin
              state_d = ST_N_RD;
            end else begin
              e_idx_d = 1'b1;
              state_d = ST_E_RDIN;
            end
          end else begin
            k_d = k_q + 1'b1;
            state_d = ST_E_RDIN;
          end
        end
      end
      ST_N_RD: begin
        cmd_o.rd_slot = tri_q[t_q][vi_q];
        state_d = ST_N_GO;
      end
      ST_N_GO: begin
        cmd_o.op = OP_NDC;
        cmd_o.md_start = 1'b1;
        state_d = ST_N_WAIT;
      end
      ST_N_WAIT: begin
        cmd_o.op = OP_NDC;
        cmd_o.ndc_wr = 1'b1;
        if (sts_i.md_done) begin
          if (k_q == 2'd2) begin
            k_d = '0;
            if (vi_q == 2'd2) begin
              vi_d = '0;
              state_d = full_q ? ST_CULL : ST_S_GO;
            end else begin
              vi_d = vi_q + 1'b1;
              state_d = ST_N_RD;
            end
          end else begin
            k_d = k_q + 1'b1;
            state_d = ST_N_RD;
          end
        end
      end
      ST_CULL: begin
        state_d = sts_i.cull ? ST_IDLE : ST_S_GO;
      end
      ST_S_GO: begin
        cmd_o.op = OP_SCR;
        cmd_o.scr_wr = 1'b1;
        if (k_q == 2'd1) begin
          k_d = '0;
          if (vi_q == 2'd2) begin
            vi_d = '0;
            state_d = ST_OUT;
          end else begin
            vi_d = vi_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_OUT: begin
        cmd_o.out_last = (t_q == tlast_q);
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (t_q == tlast_q) begin
            state_d = ST_IDLE;
          end else begin
            t_d  = 1'b1;
            vi_d = '0;
            k_d  = '0;
            state_d = ST_N_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* hdl/triangle_near_clip_viewport_core.sv */
// Top level of the triangle near-clip viewport core; vertices 1 and 2 are stored on arrival.
// The third vertex starts the work: each divide runs in the shared unit (34 multiply and
// 68 divide steps, start, done, operand reads). A triangle needs 9 divides, 17 with one
// vertex in front and 26 for a quad; no new vertex is taken until the triangle is done.
// Reset sets width 640, height 480, near 66, vertex count 0 and no beat pending.
module triangle_near_clip_viewport_core import tncv_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] clip_x_i,
  input  logic signed [COORD_W-1:0] clip_y_i,
  input  logic signed [COORD_W-1:0] clip_z_i,
  input  logic signed [COORD_W-1:0] clip_w_i,
  input  logic [RGB_W-1:0]          color_rgb_i,
  input  logic                      color_present_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] sx0_o,
  output logic signed [COORD_W-1:0] sy0_o,
  output logic signed [COORD_W-1:0] sz0_o,
  output logic signed [COORD_W-1:0] sx1_o,
  output logic signed [COORD_W-1:0] sy1_o,
  output logic signed [COORD_W-1:0] sz1_o,
  output logic signed [COORD_W-1:0] sx2_o,
  output logic signed [COORD_W-1:0] sy2_o,
  output logic signed [COORD_W-1:0] sz2_o,
  output logic [31:0]               rgba_o,
  output logic                      last_of_run_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tncv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tncv_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .clip_x_i        (clip_x_i),
    .clip_y_i        (clip_y_i),
    .clip_z_i        (clip_z_i),
    .clip_w_i        (clip_w_i),
    .color_rgb_i     (color_rgb_i),
    .color_present_i (color_present_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .sx0_o           (sx0_o),
    .sy0_o           (sy0_o),
    .sz0_o           (sz0_o),
    .sx1_o           (sx1_o),
    .sy1_o           (sy1_o),
    .sz1_o           (sz1_o),
    .sx2_o           (sx2_o),
    .sy2_o           (sy2_o),
    .sz2_o           (sz2_o),
    .rgba_o          (rgba_o),
    .last_of_run_o   (last_of_run_o)
  );

`include "triangle_near_clip_viewport_core_assert.svh"

  `TNCV_ASSERT(a_load_free, cmd.out_load |-> sts.out_free, "output beat overwritten")
  `TNCV_ASSERT(a_vtx_unit_idle, (in_valid_i && in_ready_o) |-> !sts.md_busy, "vertex in busy")
  `TNCV_NEVER(a_one_result_wr, $countones({cmd.edge_wr, cmd.ndc_wr, cmd.scr_wr}) > 1, "two writes")

endmodule
